/* hw/rtl/rv64id_pkg.sv */
// Types and encodings for the RV64 instruction decode unit.
// Opcodes, class codes, OP-FP codes and the decoded record.
// No dependencies.
package rv64id_pkg;

	localparam int unsigned InWordW  = 32;
	localparam int unsigned OutDataW = 88;

	localparam logic [6:0] OPC_LUI      = 7'b0110111;
	localparam logic [6:0] OPC_AUIPC    = 7'b0010111;
	localparam logic [6:0] OPC_JAL      = 7'b1101111;
	localparam logic [6:0] OPC_JALR     = 7'b1100111;
	localparam logic [6:0] OPC_BRANCH   = 7'b1100011;
	localparam logic [6:0] OPC_LOAD     = 7'b0000011;
	localparam logic [6:0] OPC_STORE    = 7'b0100011;
	localparam logic [6:0] OPC_OP_IMM   = 7'b0010011;
	localparam logic [6:0] OPC_OP       = 7'b0110011;
	localparam logic [6:0] OPC_MISC_MEM = 7'b0001111;
	localparam logic [6:0] OPC_SYSTEM   = 7'b1110011;
	localparam logic [6:0] OPC_OP_IMM32 = 7'b0011011;
	localparam logic [6:0] OPC_OP32     = 7'b0111011;
	localparam logic [6:0] OPC_LOAD_FP  = 7'b0000111;
	localparam logic [6:0] OPC_STORE_FP = 7'b0100111;
	localparam logic [6:0] OPC_OP_FP    = 7'b1010011;

	// funct3 of the shift forms
	localparam logic [2:0] F3_SLL = 3'd1;
	localparam logic [2:0] F3_SR  = 3'd5;

	// OP-FP funct7 groups
	localparam logic [6:0] F7_FADD  = 7'h00;
	localparam logic [6:0] F7_FSUB  = 7'h04;
	localparam logic [6:0] F7_FMUL  = 7'h08;
	localparam logic [6:0] F7_FDIV  = 7'h0C;
	localparam logic [6:0] F7_FSGNJ = 7'h10;
	localparam logic [6:0] F7_FMVXW = 7'h70;
	localparam logic [6:0] F7_FMVWX = 7'h78;
	localparam logic [6:0] F7_FCMP  = 7'h50;
	localparam logic [6:0] F7_FCVTI = 7'h60;
	localparam logic [6:0] F7_FCVTS = 7'h68;

	typedef enum logic [4:0] {
		CLS_INVALID   = 5'd0,
		CLS_JAL       = 5'd1,
		CLS_SYSTEM    = 5'd2,
		CLS_OP_IMM    = 5'd3,
		CLS_BRANCH    = 5'd4,
		CLS_JALR      = 5'd5,
		CLS_AUIPC     = 5'd6,
		CLS_STORE     = 5'd7,
		CLS_LOAD      = 5'd8,
		CLS_OP_IMM32  = 5'd9,
		CLS_MISC_MEM  = 5'd10,
		CLS_LUI       = 5'd11,
		CLS_OP        = 5'd12,
		CLS_OP32      = 5'd13,
		CLS_LOAD_FP   = 5'd14,
		CLS_STORE_FP  = 5'd15,
		CLS_OP_FP     = 5'd16
	} insn_class_t;

	typedef enum logic [4:0] {
		FP_ADD     = 5'd0,
		FP_SUB     = 5'd1,
		FP_MUL     = 5'd2,
		FP_DIV     = 5'd3,
		FP_SGNJ    = 5'd4,
		FP_SGNJN   = 5'd5,
		FP_SGNJX   = 5'd6,
		FP_MVXW    = 5'd7,
		FP_CLASS   = 5'd8,
		FP_MVWX    = 5'd9,
		FP_EQ      = 5'd10,
		FP_LT      = 5'd11,
		FP_LE      = 5'd12,
		FP_CVT_W_S = 5'd13,
		FP_CVT_S_W = 5'd17
	} fp_op_t;

	typedef struct packed {
		insn_class_t  insn_class;
		logic [14:0]  sub_type;
		logic [31:0]  immediate;
		logic [4:0]   dest_reg;
		logic [4:0]   src1_reg;
		logic [4:0]   src2_reg;
		logic [11:0]  csr_number;
		logic [2:0]   round_mode;
		logic         fault;
	} decode_t;

endpackage

/* hw/rtl/rv64_instruction_decode_unit.sv */
// RV64 instruction decode unit: one 32-bit word in, one decoded record out.
// Depends on rv64id_pkg.
//
// Stages: an input register, then decode into the result register. Throughput:
// one word per cycle while the sink does not stall.
// Ready to the source drops only when both stages hold a word and the sink stalls.
// Reset clears both stage valid flags; payload registers are not reset.
module rv64_instruction_decode_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [rv64id_pkg::InWordW-1:0] s_axis_tdata,  // [31:0] instruction_word
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [4:0] insn_class, [19:5] sub_type, [51:20] immediate, [56:52] dest_reg,
	// [61:57] src1_reg, [66:62] src2_reg, [78:67] csr_number, [81:79] round_mode,
	// [87:82] zero
	output logic [rv64id_pkg::OutDataW-1:0] m_axis_tdata,
	output logic                          m_axis_tuser   // [0] fault
);
	import rv64id_pkg::*;

	logic                valid_s1;
	logic [InWordW-1:0]  word_s1;
	logic                valid_s2;
	decode_t             rec_s2;
	decode_t             dec;
	logic                adv_s1;

	logic [6:0]  opc;
	logic [4:0]  rd, rs1, rs2;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j, imm_sh;
	logic [4:0]  fp_sub;
	logic        fp_ok;

	assign adv_s1        = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			word_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rec_s2 <= dec;
		end
	end

	assign opc = word_s1[6:0];
	assign rd  = word_s1[11:7];
	assign f3  = word_s1[14:12];
	assign rs1 = word_s1[19:15];
	assign rs2 = word_s1[24:20];
	assign f7  = word_s1[31:25];

	assign imm_i  = {{20{word_s1[31]}}, word_s1[31:20]};
	assign imm_s  = {{20{word_s1[31]}}, word_s1[31:25], word_s1[11:7]};
	assign imm_b  = {{19{word_s1[31]}}, word_s1[31], word_s1[7], word_s1[30:25],
		word_s1[11:8], 1'b0};
	assign imm_u  = {word_s1[31:12], 12'b0};
	assign imm_j  = {{11{word_s1[31]}}, word_s1[31], word_s1[19:12], word_s1[20],
		word_s1[30:21], 1'b0};
	assign imm_sh = {26'b0, word_s1[25:20]};

	// dense OP-FP code; fp_ok low for anything malformed or unsupported
	always_comb begin
		fp_sub = 5'd0;
		fp_ok  = 1'b0;
		unique case (f7)
			F7_FADD: begin fp_sub = FP_ADD; fp_ok = 1'b1; end
			F7_FSUB: begin fp_sub = FP_SUB; fp_ok = 1'b1; end
			F7_FMUL: begin fp_sub = FP_MUL; fp_ok = 1'b1; end
			F7_FDIV: begin fp_sub = FP_DIV; fp_ok = 1'b1; end
			F7_FSGNJ: begin
				fp_sub = FP_SGNJ + {2'b0, f3};
				fp_ok  = (f3 <= 3'd2);
			end
			F7_FMVXW: begin
				fp_sub = (f3 == 3'd0) ? FP_MVXW : FP_CLASS;
				fp_ok  = (rs2 == 5'd0) && (f3 <= 3'd1);
			end
			F7_FMVWX: begin
				fp_sub = FP_MVWX;
				fp_ok  = (rs2 == 5'd0) && (f3 == 3'd0);
			end
			F7_FCMP: begin
				fp_sub = FP_LE - {2'b0, f3};
				fp_ok  = (f3 <= 3'd2);
			end
			F7_FCVTI: begin
				fp_sub = FP_CVT_W_S + rs2;
				fp_ok  = (rs2 <= 5'd3);
			end
			F7_FCVTS: begin
				fp_sub = FP_CVT_S_W + rs2;
				fp_ok  = (rs2 <= 5'd3);
			end
			default: begin
				fp_sub = 5'd0;
				fp_ok  = 1'b0;
			end
		endcase
	end

	always_comb begin
		dec = '0;
		unique case (opc)
			OPC_JAL: begin
				dec.insn_class = CLS_JAL;
				dec.immediate  = imm_j;
				dec.dest_reg   = rd;
			end
			OPC_SYSTEM: begin
				dec.insn_class = CLS_SYSTEM;
				dec.csr_number = word_s1[31:20];
				dec.src1_reg   = rs1;
				dec.dest_reg   = rd;
				dec.sub_type   = (f3 == 3'd0) ? {word_s1[31:20], 3'b0} : {12'b0, f3};
			end
			OPC_OP_IMM: begin
				dec.insn_class = CLS_OP_IMM;
				dec.src1_reg   = rs1;
				dec.dest_reg   = rd;
				if (f3 == F3_SLL || f3 == F3_SR) begin
					dec.sub_type  = {5'b0, word_s1[31:26], 1'b0, f3};
					dec.immediate = imm_sh;
				end else begin
					dec.sub_type  = {12'b0, f3};
					dec.immediate = imm_i;
				end
			end
			OPC_BRANCH: begin
				dec.insn_class = CLS_BRANCH;
				dec.sub_type   = {12'b0, f3};
				dec.immediate  = imm_b;
				dec.src1_reg   = rs1;
				dec.src2_reg   = rs2;
			end
			OPC_JALR: begin
				dec.insn_class = CLS_JALR;
				dec.immediate  = imm_i;
				dec.src1_reg   = rs1;
				dec.dest_reg   = rd;
			end
			OPC_AUIPC: begin
				dec.insn_class = CLS_AUIPC;
				dec.immediate  = imm_u;
				dec.dest_reg   = rd;
			end
			OPC_STORE: begin
				dec.insn_class = CLS_STORE;
				dec.sub_type   = {12'b0, f3};
				dec.immediate  = imm_s;
				dec.src1_reg   = rs1;
				dec.src2_reg   = rs2;
			end
			OPC_LOAD: begin
				dec.insn_class = CLS_LOAD;
				dec.sub_type   = {12'b0, f3};
				dec.immediate  = imm_i;
				dec.src1_reg   = rs1;
				dec.dest_reg   = rd;
			end
			OPC_OP_IMM32: begin
				dec.insn_class = CLS_OP_IMM32;
				dec.src1_reg   = rs1;
				dec.dest_reg   = rd;
				if (f3 == F3_SLL || f3 == F3_SR) begin
					dec.sub_type  = {5'b0, f7, f3};
					dec.immediate = imm_sh;
				end else begin
					dec.sub_type  = {12'b0, f3};
					dec.immediate = imm_i;
				end
			end
			OPC_MISC_MEM: begin
				dec.insn_class = CLS_MISC_MEM;
				dec.sub_type   = {12'b0, f3};
			end
			OPC_LUI: begin
				dec.insn_class = CLS_LUI;
				dec.immediate  = imm_u;
				dec.dest_reg   = rd;
			end
			OPC_OP, OPC_OP32: begin
				dec.insn_class = (opc == OPC_OP) ? CLS_OP : CLS_OP32;
				dec.sub_type   = {5'b0, f7, f3};
				dec.src1_reg   = rs1;
				dec.src2_reg   = rs2;
				dec.dest_reg   = rd;
			end
			OPC_LOAD_FP: begin
				dec.insn_class = CLS_LOAD_FP;
				dec.immediate  = imm_i;
				dec.src1_reg   = rs1;
				dec.dest_reg   = rd;
			end
			OPC_STORE_FP: begin
				dec.insn_class = CLS_STORE_FP;
				dec.immediate  = imm_s;
				dec.src1_reg   = rs1;
				dec.src2_reg   = rs2;
			end
			OPC_OP_FP: begin
				dec.insn_class = CLS_OP_FP;
				if (fp_ok) begin
					dec.sub_type   = {10'b0, fp_sub};
					dec.round_mode = f3;
					dec.src1_reg   = rs1;
					dec.src2_reg   = rs2;
					dec.dest_reg   = rd;
				end else begin
					dec.fault = 1'b1;
				end
			end
			default: dec = '0;
		endcase
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = rec_s2.fault;
	assign m_axis_tdata  = {6'b0, rec_s2.round_mode, rec_s2.csr_number, rec_s2.src2_reg,
		rec_s2.src1_reg, rec_s2.dest_reg, rec_s2.immediate, rec_s2.sub_type,
		rec_s2.insn_class};

	// source is held off only when both stages are full and the sink stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && valid_s2 && !m_axis_tready))
		else $error("input stalled with a free stage");

	// a faulted word carries nothing but its class
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && rec_s2.fault) |->
		(rec_s2.insn_class == CLS_OP_FP && rec_s2.sub_type == 15'd0 &&
		rec_s2.immediate == 32'd0 && rec_s2.round_mode == 3'd0))
		else $error("fault record with live fields");

	// an invalid word gives an all-zero record
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && rec_s2.insn_class == CLS_INVALID) |-> (rec_s2 == '0))
		else $error("invalid record not cleared");

	// a stalled result must not be overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !m_axis_tready) |=> $stable(rec_s2))
		else $error("held result changed");

endmodule

/* dv/rv64_instruction_decode_unit_tb.sv */
// Testbench for rv64_instruction_decode_unit: directed and shaped random words.
// Each accepted result is checked against a decoder written here.
// Depends on rv64id_pkg and the unit's RTL.
`timescale 1ns / 100ps

module rv64_instruction_decode_unit_tb;
	import rv64id_pkg::*;

	// fused multiply-add opcodes, expected to decode as invalid
	localparam logic [6:0] OPC_MADD  = 7'b1000011;
	localparam logic [6:0] OPC_MSUB  = 7'b1000111;
	localparam logic [6:0] OPC_NMSUB = 7'b1001011;
	localparam logic [6:0] OPC_NMADD = 7'b1001111;

	// funct3 selectors inside OP-FP groups
	localparam logic [2:0] F3_FLE    = 3'd0;
	localparam logic [2:0] F3_FLT    = 3'd1;
	localparam logic [2:0] F3_FEQ    = 3'd2;
	localparam logic [2:0] F3_FMV    = 3'd0;
	localparam logic [2:0] F3_FCLASS = 3'd1;
	localparam logic [2:0] F3_SGNJX  = 3'd2;

	localparam int unsigned DrainCycles = 10;
	localparam int unsigned LongHold    = 60;
	localparam int unsigned MaxPrinted  = 40;

	typedef struct packed {
		logic [31:0] word;
		logic        drain_first;
	} send_item_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [InWordW-1:0]  s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OutDataW-1:0] m_axis_tdata;
	logic                m_axis_tuser;

	send_item_t words_to_send[$];
	decode_t    records_due[$];
	decode_t    want;

	int errors = 0;
	int words_queued = 0;
	int words_sent = 0;
	int results_done = 0;
	int send_gap = 0;
	int hold_cnt = 0;
	bit long_hold_done = 1'b0;
	int n_faults = 0;
	int n_invalid = 0;
	int n_fp_ok = 0;

	rv64_instruction_decode_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #10 clk = ~clk;

	// expected decoded record for one instruction word
	function automatic decode_t decode_word(input logic [31:0] w);
		decode_t     r;
		logic [4:0]  rd, rs1, rs2, fp;
		logic [2:0]  f3;
		logic [6:0]  f7;
		logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
		logic        fp_ok;
		r = '0;
		rd = w[11:7];
		rs1 = w[19:15];
		rs2 = w[24:20];
		f3 = w[14:12];
		f7 = w[31:25];
		imm_i = {{20{w[31]}}, w[31:20]};
		imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
		imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
		imm_u = {w[31:12], 12'b0};
		imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
		fp = '0;
		fp_ok = 1'b1;
		case (w[6:0])
			OPC_JAL: begin
				r.insn_class = CLS_JAL;
				r.immediate = imm_j;
				r.dest_reg = rd;
			end
			OPC_SYSTEM: begin
				r.insn_class = CLS_SYSTEM;
				r.csr_number = w[31:20];
				r.src1_reg = rs1;
				r.dest_reg = rd;
				// funct3 of zero: sub-type carries the I-immediate shifted up by three
				r.sub_type = (f3 == 3'd0) ? {w[31:20], 3'b0} : {12'b0, f3};
			end
			OPC_OP_IMM: begin
				r.insn_class = CLS_OP_IMM;
				r.src1_reg = rs1;
				r.dest_reg = rd;
				if (f3 == F3_SLL || f3 == F3_SR) begin
					r.sub_type = {5'b0, w[31:26], 1'b0, f3};
					r.immediate = {26'b0, w[25:20]};
				end else begin
					r.sub_type = {12'b0, f3};
					r.immediate = imm_i;
				end
			end
			OPC_BRANCH: begin
				r.insn_class = CLS_BRANCH;
				r.sub_type = {12'b0, f3};
				r.immediate = imm_b;
				r.src1_reg = rs1;
				r.src2_reg = rs2;
			end
			OPC_JALR: begin
				r.insn_class = CLS_JALR;
				r.immediate = imm_i;
				r.src1_reg = rs1;
				r.dest_reg = rd;
			end
			OPC_AUIPC: begin
				r.insn_class = CLS_AUIPC;
				r.immediate = imm_u;
				r.dest_reg = rd;
			end
			OPC_STORE: begin
				r.insn_class = CLS_STORE;
				r.sub_type = {12'b0, f3};
				r.immediate = imm_s;
				r.src1_reg = rs1;
				r.src2_reg = rs2;
			end
			OPC_LOAD: begin
				r.insn_class = CLS_LOAD;
				r.sub_type = {12'b0, f3};
				r.immediate = imm_i;
				r.src1_reg = rs1;
				r.dest_reg = rd;
			end
			OPC_OP_IMM32: begin
				r.insn_class = CLS_OP_IMM32;
				r.src1_reg = rs1;
				r.dest_reg = rd;
				if (f3 == F3_SLL || f3 == F3_SR) begin
					r.sub_type = {5'b0, f7, f3};
					r.immediate = {26'b0, w[25:20]};
				end else begin
					r.sub_type = {12'b0, f3};
					r.immediate = imm_i;
				end
			end
			OPC_MISC_MEM: begin
				r.insn_class = CLS_MISC_MEM;
				r.sub_type = {12'b0, f3};
			end
			OPC_LUI: begin
				r.insn_class = CLS_LUI;
				r.immediate = imm_u;
				r.dest_reg = rd;
			end
			OPC_OP, OPC_OP32: begin
				r.insn_class = (w[6:0] == OPC_OP) ? CLS_OP : CLS_OP32;
				r.sub_type = {5'b0, f7, f3};
				r.src1_reg = rs1;
				r.src2_reg = rs2;
				r.dest_reg = rd;
			end
			OPC_LOAD_FP: begin
				r.insn_class = CLS_LOAD_FP;
				r.immediate = imm_i;
				r.src1_reg = rs1;
				r.dest_reg = rd;
			end
			OPC_STORE_FP: begin
				r.insn_class = CLS_STORE_FP;
				r.immediate = imm_s;
				r.src1_reg = rs1;
				r.src2_reg = rs2;
			end
			OPC_OP_FP: begin
				r.insn_class = CLS_OP_FP;
				case (f7)
					F7_FADD: fp = FP_ADD;
					F7_FSUB: fp = FP_SUB;
					F7_FMUL: fp = FP_MUL;
					F7_FDIV: fp = FP_DIV;
					F7_FSGNJ: begin
						fp_ok = (f3 <= F3_SGNJX);
						fp = FP_SGNJ + {2'b0, f3};
					end
					F7_FMVXW: begin
						fp_ok = (rs2 == 5'd0) && (f3 == F3_FMV || f3 == F3_FCLASS);
						fp = (f3 == F3_FMV) ? FP_MVXW : FP_CLASS;
					end
					F7_FMVWX: begin
						fp_ok = (rs2 == 5'd0) && (f3 == F3_FMV);
						fp = FP_MVWX;
					end
					F7_FCMP: begin
						fp_ok = (f3 == F3_FEQ || f3 == F3_FLT || f3 == F3_FLE);
						fp = (f3 == F3_FEQ) ? FP_EQ : (f3 == F3_FLT) ? FP_LT : FP_LE;
					end
					F7_FCVTI: begin
						fp_ok = (rs2 <= 5'd3);
						fp = FP_CVT_W_S + rs2;
					end
					F7_FCVTS: begin
						fp_ok = (rs2 <= 5'd3);
						fp = FP_CVT_S_W + rs2;
					end
					default: fp_ok = 1'b0;
				endcase
				if (fp_ok) begin
					r.sub_type = {10'b0, fp};
					r.round_mode = f3;
					r.src1_reg = rs1;
					r.src2_reg = rs2;
					r.dest_reg = rd;
				end else begin
					r.fault = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [6:0] any_opcode(input int k);
		case (k)
			0: return OPC_LUI;
			1: return OPC_AUIPC;
			2: return OPC_JAL;
			3: return OPC_JALR;
			4: return OPC_BRANCH;
			5: return OPC_LOAD;
			6: return OPC_STORE;
			7: return OPC_OP_IMM;
			8: return OPC_OP;
			9: return OPC_MISC_MEM;
			10: return OPC_SYSTEM;
			11: return OPC_OP_IMM32;
			12: return OPC_OP32;
			13: return OPC_LOAD_FP;
			14: return OPC_STORE_FP;
			default: return OPC_OP_FP;
		endcase
	endfunction

	function automatic logic [6:0] fma_opcode(input int k);
		case (k)
			0: return OPC_MADD;
			1: return OPC_MSUB;
			2: return OPC_NMSUB;
			default: return OPC_NMADD;
		endcase
	endfunction

	function automatic logic [6:0] fp_group(input int k);
		case (k)
			0: return F7_FADD;
			1: return F7_FSUB;
			2: return F7_FMUL;
			3: return F7_FDIV;
			4: return F7_FSGNJ;
			5: return F7_FMVXW;
			6: return F7_FMVWX;
			7: return F7_FCMP;
			8: return F7_FCVTI;
			9: return F7_FCVTS;
			default: return 7'($urandom);
		endcase
	endfunction

	// mostly real encodings with random fields; some raw noise and FMA words
	function automatic logic [31:0] gen_word();
		int          k;
		logic [31:0] w;
		k = $urandom_range(0, 99);
		w = $urandom;
		if (k < 8)
			return w;
		if (k < 12) begin
			w[6:0] = fma_opcode($urandom_range(0, 3));
			return w;
		end
		if (k < 40) begin
			w[6:0] = OPC_OP_FP;
			w[31:25] = fp_group($urandom_range(0, 10));
			if ($urandom_range(0, 3) != 0)
				w[24:20] = 5'($urandom_range(0, 4));
			if ($urandom_range(0, 2) != 0)
				w[14:12] = 3'($urandom_range(0, 3));
			return w;
		end
		w[6:0] = any_opcode($urandom_range(0, 14));
		if ((w[6:0] == OPC_OP || w[6:0] == OPC_OP32) && $urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 2))
				0: w[31:25] = 7'h00;
				1: w[31:25] = 7'h20;
				default: w[31:25] = 7'h01;
			endcase
		end
		return w;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	task automatic flag_mismatch(input string msg);
		errors++;
		if (errors <= MaxPrinted)
			$display("%0t mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (got !== exp_val)
			flag_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, exp_val));
	endtask

	task automatic queue_word(input logic [31:0] w, input logic drain_first);
		send_item_t it;
		it.word = w;
		it.drain_first = drain_first;
		words_to_send.push_back(it);
		words_queued++;
	endtask

	// source side
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				records_due.push_back(decode_word(s_axis_tdata));
				words_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
					s_axis_tdata <= $urandom;
				end else if (words_to_send.size() > 0 &&
						!(words_to_send[0].drain_first && results_done != words_sent)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= words_to_send[0].word;
					void'(words_to_send.pop_front());
					// no idling on every fourth block of a hundred words
					send_gap <= ((words_sent / 100) % 4 == 3) ? 0 : draw_gap();
				end else begin
					s_axis_tvalid <= 1'b0;
					s_axis_tdata <= $urandom;
				end
			end
		end
	end

	// sink ready, with one long hold-off once the stream is going
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_axis_tready <= 1'b0;
		end else if (!long_hold_done && results_done >= 150) begin
			long_hold_done <= 1'b1;
			hold_cnt <= LongHold;
			m_axis_tready <= 1'b0;
		end else if ((results_done / 100) % 4 == 1) begin
			m_axis_tready <= 1'b1;
		end else begin
			int g;
			g = draw_gap();
			m_axis_tready <= (g == 0);
			if (g > 0)
				hold_cnt <= g - 1;
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_done <= results_done + 1;
			if (records_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected word 0x%0h", m_axis_tdata));
			end else begin
				want = records_due.pop_front();
				check_field("insn_class", 32'(m_axis_tdata[4:0]), 32'(want.insn_class));
				check_field("sub_type", 32'(m_axis_tdata[19:5]), 32'(want.sub_type));
				check_field("immediate", m_axis_tdata[51:20], want.immediate);
				check_field("dest_reg", 32'(m_axis_tdata[56:52]), 32'(want.dest_reg));
				check_field("src1_reg", 32'(m_axis_tdata[61:57]), 32'(want.src1_reg));
				check_field("src2_reg", 32'(m_axis_tdata[66:62]), 32'(want.src2_reg));
				check_field("csr_number", 32'(m_axis_tdata[78:67]), 32'(want.csr_number));
				check_field("round_mode", 32'(m_axis_tdata[81:79]), 32'(want.round_mode));
				check_field("pad", 32'(m_axis_tdata[87:82]), 32'd0);
				check_field("fault", 32'(m_axis_tuser), 32'(want.fault));
				if (want.fault)
					n_faults++;
				else if (want.insn_class == CLS_OP_FP)
					n_fp_ok++;
				if (want.insn_class == CLS_INVALID)
					n_invalid++;
			end
		end
	end

	initial begin : stimulus
		int i;

		// directed: field extremes, every class, FP corner cases
		queue_word(32'h0000_0000, 1'b0);
		queue_word(32'hFFFF_FFFF, 1'b0);
		queue_word({20'hFFFFF, 5'd31, OPC_LUI}, 1'b0);
		queue_word({20'h80000, 5'd0, OPC_AUIPC}, 1'b0);
		queue_word({20'hFFFFF, 5'd31, OPC_JAL}, 1'b0);
		queue_word({20'h7FFFF, 5'd1, OPC_JAL}, 1'b0);
		queue_word({12'h800, 5'd31, 3'd0, 5'd31, OPC_JALR}, 1'b0);
		queue_word({7'h7F, 5'd31, 5'd31, 3'd7, 5'd31, OPC_BRANCH}, 1'b0);
		queue_word({12'h7FF, 5'd1, 3'd3, 5'd2, OPC_LOAD}, 1'b0);
		queue_word({7'h40, 5'd3, 5'd4, 3'd3, 5'd0, OPC_STORE}, 1'b0);
		queue_word({6'h10, 6'h3F, 5'd5, F3_SR, 5'd6, OPC_OP_IMM}, 1'b0);
		queue_word({12'hFFF, 5'd7, 3'd0, 5'd8, OPC_OP_IMM}, 1'b0);
		queue_word({7'h20, 5'd31, 5'd9, F3_SR, 5'd10, OPC_OP_IMM32}, 1'b0);
		queue_word({7'h01, 5'd2, 5'd3, 3'd0, 5'd4, OPC_OP}, 1'b0);
		queue_word({7'h20, 5'd5, 5'd6, 3'd0, 5'd7, OPC_OP32}, 1'b0);
		queue_word({12'h0FF, 5'd0, 3'd0, 5'd0, OPC_MISC_MEM}, 1'b0);
		queue_word({12'h800, 5'd0, 3'd0, 5'd0, OPC_SYSTEM}, 1'b0);
		queue_word({12'hFFF, 5'd31, 3'd7, 5'd31, OPC_SYSTEM}, 1'b0);
		queue_word({12'h800, 5'd11, 3'd2, 5'd12, OPC_LOAD_FP}, 1'b0);
		queue_word({7'h3F, 5'd13, 5'd14, 3'd2, 5'd31, OPC_STORE_FP}, 1'b0);
		queue_word({F7_FADD, 5'd1, 5'd2, 3'd7, 5'd3, OPC_OP_FP}, 1'b0);
		queue_word({F7_FCVTS, 5'd3, 5'd4, 3'd1, 5'd5, OPC_OP_FP}, 1'b0);
		// min/max, moves with rs2 set, compare with bad funct3
		queue_word({7'h14, 5'd1, 5'd2, 3'd0, 5'd3, OPC_OP_FP}, 1'b0);
		queue_word({F7_FMVXW, 5'd1, 5'd2, F3_FMV, 5'd3, OPC_OP_FP}, 1'b0);
		queue_word({F7_FCMP, 5'd0, 5'd2, 3'd3, 5'd3, OPC_OP_FP}, 1'b0);
		queue_word({25'h1FF_FFFF, OPC_MADD}, 1'b0);

		for (i = 0; i < 400; i++)
			queue_word(gen_word(), 1'b0);
		// second half starts only once the pipeline has emptied
		queue_word(gen_word(), 1'b1);
		for (i = 0; i < 400; i++)
			queue_word(gen_word(), 1'b0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// every queued word must come back before the run can end
		while (results_done != words_queued)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("%0d words checked: %0d valid OP-FP, %0d OP-FP faults, %0d invalid",
			results_done, n_fp_ok, n_faults, n_invalid);
		$display("covered all classes, FMA opcodes, a long output stall and a drained pause");
		if (errors == 0)
			$display("rv64_instruction_decode_unit_tb OK");
		else
			$display("rv64_instruction_decode_unit_tb NOT OK");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("rv64_instruction_decode_unit_tb NOT OK");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/rv64id_pkg.sv
hw/rtl/rv64_instruction_decode_unit.sv
dv/rv64_instruction_decode_unit_tb.sv
